@@ rtl/fba_pkg.sv @@
// fba_pkg: item types, status codes and register indexes of the fixed block allocator
// no dependencies; imported by fba_map and fixed_block_allocator
`default_nettype none

package fba_pkg;

   // free bitmap word: 64 blocks per memory word
   localparam int WORD_BITS = 64;
   localparam int WORD_LSB  = 6;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NONE_FREE = 2'd2,
      ST_BAD_FREE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_BASE_ADDR     = 2'd0,
      REG_BLOCK_SHIFT   = 2'd1,
      REG_REGION_BLOCKS = 2'd2,
      REG_NONE          = 2'd3
   } reg_index_type;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [31:0] req_bytes;
      logic [31:0] free_addr;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] block_addr;
   } rsp_item_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } map_ctl_type;

endpackage

`default_nettype wire

@@ rtl/fixed_block_allocator.sv @@
// fixed_block_allocator: top level, csr port, sequencer and shared shifter
// depends on fba_pkg and fba_map
`default_nettype none

// Hands out and takes back equal-sized blocks of the region at base_addr, lowest free
// block first. An item is taken when start is high and busy is low; its one result
// appears on rsp_item for a single cycle marked by rsp_valid and cannot be held off.
// After reset the free bitmap (64 blocks per memory word) is swept to all free, which
// keeps busy high until the sweep is done. An allocate scans the bitmap one memory
// word per cycle through the single read port and takes the first word holding a
// free block; an allocate that finds nothing reports none free after the last used
// word, and one that is too large or meets an empty region is refused before the
// scan. A free goes through offset subtract, shift, range check and read, then bit
// check and write back; a free that is out of range or off a block boundary is
// refused at the range check. One barrel shifter serves both the block address of
// an allocate and the block index of a free. The next item may be taken in the cycle
// its predecessor's result is shown.

module fixed_block_allocator
   import fba_pkg::*;
#(
   parameter int NUM_BLOCKS = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // item channel
   input  wire logic         start,
   output logic              busy,
   input  wire req_item_type req_item,
   // result channel
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   // register port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int WP_W      = $clog2(NUM_WORDS + 1);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_ACHK   = 8'b0000_0010,
      S_SCAN   = 8'b0000_0100,
      S_ADDR   = 8'b0000_1000,
      S_SUM    = 8'b0001_0000,
      S_FSHIFT = 8'b0010_0000,
      S_FCHK   = 8'b0100_0000,
      S_FRD    = 8'b1000_0000
   } state_type;

   // lowest set bit of a bitmap word
   function automatic logic [WORD_LSB-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [WORD_LSB-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = WORD_LSB'(i);
         end
      end
      return pos;
   endfunction

   // configuration registers
   logic [31:0] base_addr_ff;
   logic [4:0]  block_shift_ff;
   logic [10:0] region_blocks_ff;

   // sequencer state
   state_type    state_ff, state_in;
   req_item_type item_ff, item_in;
   logic [31:0]  opd_ff, opd_in;
   logic [31:0]  sh_ff, sh_in;
   logic         misalign_ff, misalign_in;
   logic [WP_W-1:0] word_ptr_ff, word_ptr_in;
   logic [WA_W-1:0] eval_ff, eval_in;
   logic         data_vld_ff, data_vld_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   // bitmap port
   map_ctl_type          map_ctl;
   logic [WA_W-1:0]      map_rd_addr;
   logic [WA_W-1:0]      map_wr_addr;
   logic [WORD_BITS-1:0] map_wr_data;
   logic [WORD_BITS-1:0] map_rd_data;
   logic                 map_ready;

   // derived figures
   logic [31:0] n_usable;
   logic [31:0] words_used;
   logic [31:0] bsize;
   logic [31:0] low_mask;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] hits;
   logic [WORD_LSB-1:0]  hit_pos;
   logic        sh_left;
   logic        accept;
   logic        csr_wr;
   reg_index_type csr_idx;

   // ---------------------------------------------------------------- register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_addr_ff     <= 32'd0;
         block_shift_ff   <= 5'd12;
         region_blocks_ff <= 11'd1024;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BASE_ADDR:     base_addr_ff     <= csr_pwdata;
            REG_BLOCK_SHIFT:   block_shift_ff   <= csr_pwdata[4:0];
            REG_REGION_BLOCKS: region_blocks_ff <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_BASE_ADDR:     csr_prdata = base_addr_ff;
         REG_BLOCK_SHIFT:   csr_prdata = {27'd0, block_shift_ff};
         REG_REGION_BLOCKS: csr_prdata = {21'd0, region_blocks_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- figures
   // only the first NUM_BLOCKS blocks of a larger region are managed
   assign n_usable   = (32'(region_blocks_ff) > NUM_BLOCKS) ? 32'(NUM_BLOCKS)
                                                            : 32'(region_blocks_ff);
   assign words_used = (n_usable + 32'(WORD_BITS - 1)) >> WORD_LSB;
   assign bsize      = 32'd1 << block_shift_ff;
   assign low_mask   = ~(32'hFFFF_FFFF << block_shift_ff);

   // blocks past the region end in the last word never match
   always_comb begin
      valid_mask = {WORD_BITS{1'b1}};
      if ((32'(eval_ff) == words_used - 32'd1) && (n_usable[WORD_LSB-1:0] != '0)) begin
         valid_mask = ~({WORD_BITS{1'b1}} << n_usable[WORD_LSB-1:0]);
      end
   end

   assign hits    = map_rd_data & valid_mask;
   assign hit_pos = lowest_set(hits);

   // the one shifter: block index to byte offset, or byte offset to block index
   assign sh_left = (state_ff == S_ADDR);
   assign sh_in   = sh_left ? (opd_ff << block_shift_ff) : (opd_ff >> block_shift_ff);

   assign busy   = (state_ff != S_IDLE) | ~map_ready;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      opd_in       = opd_ff;
      misalign_in  = misalign_ff;
      word_ptr_in  = word_ptr_ff;
      eval_in      = eval_ff;
      data_vld_in  = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      map_ctl      = '0;
      map_rd_addr  = word_ptr_ff[WA_W-1:0];
      map_wr_addr  = eval_ff;
      map_wr_data  = map_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_item;
               if (req_item.func == FUNC_FREE) begin
                  opd_in   = req_item.free_addr - base_addr_ff;
                  state_in = S_FSHIFT;
               end else begin
                  state_in = S_ACHK;
               end
            end
         end
         S_ACHK: begin
            word_ptr_in = '0;
            if (item_ff.req_bytes > bsize) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_TOO_LARGE, block_addr: 32'd0};
               state_in     = S_IDLE;
            end else if (n_usable == 32'd0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_NONE_FREE, block_addr: 32'd0};
               state_in     = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // read one word a cycle, judge the word read the cycle before
            if (32'(word_ptr_ff) < words_used) begin
               map_ctl.rd_en = 1'b1;
               word_ptr_in   = word_ptr_ff + WP_W'(1);
               eval_in       = word_ptr_ff[WA_W-1:0];
               data_vld_in   = 1'b1;
            end
            if (data_vld_ff) begin
               if (hits != '0) begin
                  map_ctl.wr_en = 1'b1;
                  map_wr_addr   = eval_ff;
                  map_wr_data   = map_rd_data & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << hit_pos);
                  opd_in        = (32'(eval_ff) << WORD_LSB) | 32'(hit_pos);
                  data_vld_in   = 1'b0;
                  state_in      = S_ADDR;
               end else if (32'(eval_ff) == words_used - 32'd1) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_NONE_FREE, block_addr: 32'd0};
                  data_vld_in  = 1'b0;
                  state_in     = S_IDLE;
               end
            end
         end
         S_ADDR: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_OK, block_addr: base_addr_ff + sh_ff};
            state_in     = S_IDLE;
         end
         S_FSHIFT: begin
            misalign_in = (opd_ff & low_mask) != 32'd0;
            state_in    = S_FCHK;
         end
         S_FCHK: begin
            if (misalign_ff || (sh_ff >= n_usable)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_BAD_FREE, block_addr: 32'd0};
               state_in     = S_IDLE;
            end else begin
               map_ctl.rd_en = 1'b1;
               map_rd_addr   = sh_ff[WA_W+WORD_LSB-1:WORD_LSB];
               state_in      = S_FRD;
            end
         end
         S_FRD: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (map_rd_data[sh_ff[WORD_LSB-1:0]]) begin
               // already free
               rsp_in = '{status: ST_BAD_FREE, block_addr: 32'd0};
            end else begin
               map_ctl.wr_en = 1'b1;
               map_wr_addr   = sh_ff[WA_W+WORD_LSB-1:WORD_LSB];
               map_wr_data   = map_rd_data
                             | ({{(WORD_BITS-1){1'b0}}, 1'b1} << sh_ff[WORD_LSB-1:0]);
               rsp_in        = '{status: ST_OK, block_addr: 32'd0};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      opd_ff      <= opd_in;
      sh_ff       <= sh_in;
      misalign_ff <= misalign_in;
      word_ptr_ff <= word_ptr_in;
      eval_ff     <= eval_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // ---------------------------------------------------------------- bitmap
   fba_map #(
      .NUM_WORDS (NUM_WORDS),
      .WA_W      (WA_W)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .ctl     (map_ctl),
      .rd_addr (map_rd_addr),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_data (map_rd_data),
      .ready   (map_ready)
   );

   // ---------------------------------------------------------------- checks
   // a taken item always leaves the sequencer busy past the cycle it is taken in
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("item taken but block not busy");

   // one strobe per item, never two in a row
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");

   // only a granted block carries an address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ST_OK)) |-> (rsp_item.block_addr == 32'd0))
      else $error("failed item carries an address");

   // nothing is sequenced while the bitmap is still being cleared
   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      !map_ready |-> (state_ff == S_IDLE))
      else $error("sequencer active during bitmap clear");

endmodule

`default_nettype wire

@@ rtl/fba_map.sv @@
// fba_map: free bitmap memory, one word per access, registered read data
// clears itself to all free after reset; depends on fba_pkg
`default_nettype none

module fba_map
   import fba_pkg::*;
#(
   parameter int NUM_WORDS = 16,
   parameter int WA_W      = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire map_ctl_type          ctl,
   input  wire logic [WA_W-1:0]      rd_addr,
   input  wire logic [WA_W-1:0]      wr_addr,
   input  wire logic [WORD_BITS-1:0] wr_data,
   output logic [WORD_BITS-1:0]      rd_data,
   output logic                      ready
);

   logic [WORD_BITS-1:0] mem_ff [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WA_W-1:0]      clr_ptr_ff, clr_ptr_in;
   logic                 ready_ff, ready_in;
   logic                 we;
   logic [WA_W-1:0]      wa;
   logic [WORD_BITS-1:0] wd;

   // sweep one word a cycle until the whole map reads free
   always_comb begin
      clr_ptr_in = clr_ptr_ff;
      ready_in   = ready_ff;
      if (!ready_ff) begin
         clr_ptr_in = clr_ptr_ff + WA_W'(1);
         if (32'(clr_ptr_ff) == NUM_WORDS - 1) begin
            ready_in = 1'b1;
         end
      end
      we = ready_ff ? ctl.wr_en : 1'b1;
      wa = ready_ff ? wr_addr : clr_ptr_ff;
      wd = ready_ff ? wr_data : {WORD_BITS{1'b1}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         ready_ff   <= 1'b0;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
         ready_ff   <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ready_ff;

endmodule

`default_nettype wire
